>>> hdl/rbdq_pkg.sv
// Shared types and constants for the reversible byte deque.
package rbdq_pkg;

  // Default number of byte cells in the deque.
  localparam int DEPTH_DEF = 1024;

  // Field widths of the stream items.
  localparam int MODE_W      = 3;
  localparam int VALUE_W     = 8;
  localparam int INDEX_W     = 10;
  localparam int DATA_W      = 8;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 24;

  // Operation codes carried in the input tuser field.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_REVERSE    = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_READ       = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic shr;      // every cell takes its left neighbor's byte
    logic shl;      // every cell takes its right neighbor's byte
    logic wr;       // the cell at the write position takes the pushed byte
    logic coll_ld;  // every collect register copies its cell's byte
    logic coll_sh;  // collect registers move one cell toward cell zero
  } cell_ctl_t;

endpackage

>>> hdl/rbdq_cell.sv
// One storage cell of the deque row with its collect register.
module rbdq_cell #(
  parameter int AW  = 10,
  parameter int IDX = 0
) (
  input  logic                             clk,
  input  rbdq_pkg::cell_ctl_t              ctl,
  input  logic [rbdq_pkg::VALUE_W-1:0]     wr_value,
  input  logic [AW-1:0]                    wr_pos,
  input  logic [rbdq_pkg::VALUE_W-1:0]     left_byte,
  input  logic [rbdq_pkg::VALUE_W-1:0]     right_byte,
  input  logic [rbdq_pkg::VALUE_W-1:0]     right_coll,
  output logic [rbdq_pkg::VALUE_W-1:0]     byte_q,
  output logic [rbdq_pkg::VALUE_W-1:0]     coll_q
);

  logic [rbdq_pkg::VALUE_W-1:0] byte_r, byte_nxt;
  logic [rbdq_pkg::VALUE_W-1:0] coll_r, coll_nxt;
  logic                         wr_hit;

  // This cell is the target of a physical back push.
  assign wr_hit = ctl.wr && (wr_pos == AW'(IDX));

  // Stored byte: shift in from a neighbor, take a push, or hold.
  always_comb begin
    priority if (ctl.shr) begin
      byte_nxt = left_byte;
    end else if (ctl.shl) begin
      byte_nxt = right_byte;
    end else if (wr_hit) begin
      byte_nxt = wr_value;
    end else begin
      byte_nxt = byte_r;
    end
  end

  // Collect register: snapshot of the row that drains toward cell zero.
  always_comb begin
    priority if (ctl.coll_ld) begin
      coll_nxt = byte_r;
    end else if (ctl.coll_sh) begin
      coll_nxt = right_coll;
    end else begin
      coll_nxt = coll_r;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    coll_r <= coll_nxt;
  end

  assign byte_q = byte_r;
  assign coll_q = coll_r;

endmodule

>>> hdl/rbdq_ctrl.sv
// Operation sequencer: fill count, orientation, cell control and result register.
module rbdq_ctrl #(
  parameter int DEPTH = rbdq_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rbdq_pkg::MODE_W-1:0]      mode,
  input  logic [rbdq_pkg::INDEX_W-1:0]     index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [rbdq_pkg::DATA_W-1:0]      data,
  output logic                             ok,
  output logic [rbdq_pkg::COUNT_W-1:0]     count,
  output logic                             reversed,
  input  logic [rbdq_pkg::VALUE_W-1:0]     byte0,
  input  logic [rbdq_pkg::VALUE_W-1:0]     coll0,
  output rbdq_pkg::cell_ctl_t              ctl,
  output logic [AW-1:0]                    wr_pos
);

  localparam int XW = (CW > rbdq_pkg::INDEX_W) ? CW : rbdq_pkg::INDEX_W;

  typedef enum logic {
    ST_IDLE,
    ST_COLLECT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                fill_r, fill_nxt;
  logic                         flip_r, flip_nxt;
  logic                         pop_r, pop_nxt;
  logic [AW-1:0]                cnt_r, cnt_nxt;
  logic                         ov_r, ov_nxt;
  logic [rbdq_pkg::DATA_W-1:0]  data_r, data_nxt;
  logic                         ok_r, ok_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         rev_r, rev_nxt;

  logic                         accept;
  logic                         slot_free;
  logic                         full;
  logic                         empty;
  logic                         push_front;
  logic                         pop_front;
  logic [CW-1:0]                fill_m1;
  logic [XW-1:0]                idx_x;
  logic [XW-1:0]                fill_x;
  logic [XW-1:0]                rd_pos_x;

  // Handshake: one operation at a time, result slot must be free at the edge.
  assign slot_free = !ov_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  // Physical end chosen by the logical end and the orientation.
  assign push_front = (mode == rbdq_pkg::MODE_PUSH_FRONT) != flip_r;
  assign pop_front  = (mode == rbdq_pkg::MODE_POP_FRONT) != flip_r;
  assign full       = (fill_r == CW'(DEPTH));
  assign empty      = (fill_r == '0);
  assign fill_m1    = fill_r - 1'b1;

  // Physical position of a logical read index.
  assign idx_x    = XW'(index);
  assign fill_x   = XW'(fill_r);
  assign rd_pos_x = flip_r ? (fill_x - idx_x - 1'b1) : idx_x;

  assign wr_pos = fill_r[AW-1:0];

  // Next-state logic for the sequencer and the result register.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    flip_nxt  = flip_r;
    pop_nxt   = pop_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && !out_ready;
    data_nxt  = data_r;
    ok_nxt    = ok_r;
    count_nxt = count_r;
    rev_nxt   = rev_r;
    ctl       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ov_nxt   = 1'b1;
          data_nxt = '0;
          ok_nxt   = 1'b0;
          unique case (mode)
            rbdq_pkg::MODE_PUSH_FRONT, rbdq_pkg::MODE_PUSH_BACK: begin
              if (!full) begin
                if (push_front) begin
                  ctl.shr = 1'b1;
                end else begin
                  ctl.wr = 1'b1;
                end
                fill_nxt = fill_r + 1'b1;
                ok_nxt   = 1'b1;
              end
            end
            rbdq_pkg::MODE_REVERSE: begin
              flip_nxt = !flip_r;
              ok_nxt   = 1'b1;
            end
            rbdq_pkg::MODE_POP_FRONT, rbdq_pkg::MODE_POP_BACK: begin
              if (!empty) begin
                if (pop_front) begin
                  // Cell zero is read directly and the row closes up.
                  ctl.shl  = 1'b1;
                  data_nxt = byte0;
                  fill_nxt = fill_m1;
                  ok_nxt   = 1'b1;
                end else begin
                  // The last filled cell is fetched through the collect chain.
                  ctl.coll_ld = 1'b1;
                  cnt_nxt     = fill_m1[AW-1:0];
                  pop_nxt     = 1'b1;
                  ov_nxt      = 1'b0;
                  state_nxt   = ST_COLLECT;
                end
              end
            end
            rbdq_pkg::MODE_READ: begin
              if (idx_x < fill_x) begin
                ctl.coll_ld = 1'b1;
                cnt_nxt     = rd_pos_x[AW-1:0];
                pop_nxt     = 1'b0;
                ov_nxt      = 1'b0;
                state_nxt   = ST_COLLECT;
              end
            end
            rbdq_pkg::MODE_CLEAR: begin
              fill_nxt = '0;
              flip_nxt = 1'b0;
              ok_nxt   = 1'b1;
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
          count_nxt = fill_nxt;
          rev_nxt   = flip_nxt;
        end
      end
      ST_COLLECT: begin
        if (cnt_r != '0) begin
          ctl.coll_sh = 1'b1;
          cnt_nxt     = cnt_r - 1'b1;
        end else if (slot_free) begin
          // The wanted byte has reached cell zero.
          ov_nxt    = 1'b1;
          data_nxt  = coll0;
          ok_nxt    = 1'b1;
          if (pop_r) begin
            fill_nxt = fill_m1;
          end
          count_nxt = pop_r ? fill_m1 : fill_r;
          rev_nxt   = flip_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      flip_r  <= 1'b0;
      pop_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      flip_r  <= flip_nxt;
      pop_r   <= pop_nxt;
      ov_r    <= ov_nxt;
    end
    cnt_r   <= cnt_nxt;
    data_r  <= data_nxt;
    ok_r    <= ok_nxt;
    count_r <= count_nxt;
    rev_r   <= rev_nxt;
  end

  assign out_valid = ov_r;
  assign data      = data_r;
  assign ok        = ok_r;
  assign count     = rbdq_pkg::COUNT_W'(count_r);
  assign reversed  = rev_r;

endmodule

>>> hdl/reversible_byte_deque_unit.sv
// Top level of the reversible byte deque: sequencer and row of byte cells.
//
// A byte deque of DEPTH entries held in a row of cells, with the physical
// front always in cell zero. One operation is taken per transfer and gives
// one result transfer. Push front, push back, reverse, clear, failed
// operations and pops at the physical front register their result as they
// are taken. Reads by index and pops at the physical back fetch a byte
// through the collect chain, which moves one cell toward cell zero per
// cycle; the result is registered once the byte is in cell zero and the
// result register is free. A new operation is taken once the sequencer is
// idle and the result register is empty or being emptied in the same cycle.
// The orientation flag swaps the physical ends, so reversing moves no bytes.
// There is no clearing pass after reset.
module reversible_byte_deque_unit #(
  parameter int DEPTH = rbdq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input fields from bit 0: value[7:0], index[17:8], zero padding.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rbdq_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Input tuser from bit 0: mode[2:0].
  input  logic [rbdq_pkg::MODE_W-1:0]         in_tuser,
  // Result fields from bit 0: data[7:0], count[18:8], reversed[19], padding.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rbdq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Result tuser from bit 0: ok[0].
  output logic                                out_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PAD_W = rbdq_pkg::OUT_TDATA_W - rbdq_pkg::DATA_W - rbdq_pkg::COUNT_W - 1;

  logic [rbdq_pkg::VALUE_W-1:0]  in_value;
  logic [rbdq_pkg::INDEX_W-1:0]  in_index;
  logic [rbdq_pkg::DATA_W-1:0]   res_data;
  logic                          res_ok;
  logic [rbdq_pkg::COUNT_W-1:0]  res_count;
  logic                          res_rev;
  rbdq_pkg::cell_ctl_t           ctl;
  logic [AW-1:0]                 wr_pos;
  logic [rbdq_pkg::VALUE_W-1:0]  byte_w [DEPTH];
  logic [rbdq_pkg::VALUE_W-1:0]  coll_w [DEPTH];

  // Unpack the input transfer.
  assign in_value = in_tdata[7:0];
  assign in_index = in_tdata[17:8];

  rbdq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .mode      (in_tuser),
    .index     (in_index),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .data      (res_data),
    .ok        (res_ok),
    .count     (res_count),
    .reversed  (res_rev),
    .byte0     (byte_w[0]),
    .coll0     (coll_w[0]),
    .ctl       (ctl),
    .wr_pos    (wr_pos)
  );

  // Row of cells; cell zero takes the pushed byte on a front push.
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [rbdq_pkg::VALUE_W-1:0] left_b;
    logic [rbdq_pkg::VALUE_W-1:0] right_b;
    logic [rbdq_pkg::VALUE_W-1:0] right_c;

    if (k == 0) begin : g_first
      assign left_b = in_value;
    end else begin : g_inner_l
      assign left_b = byte_w[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_b = byte_w[k];
      assign right_c = coll_w[k];
    end else begin : g_inner_r
      assign right_b = byte_w[k+1];
      assign right_c = coll_w[k+1];
    end

    rbdq_cell #(
      .AW  (AW),
      .IDX (k)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_value   (in_value),
      .wr_pos     (wr_pos),
      .left_byte  (left_b),
      .right_byte (right_b),
      .right_coll (right_c),
      .byte_q     (byte_w[k]),
      .coll_q     (coll_w[k])
    );
  end

  // Pack the result transfer.
  assign out_tdata = {{PAD_W{1'b0}}, res_rev, res_count, res_data};
  assign out_tuser = res_ok;

endmodule

>>> hdl/rbdq_checker.sv
// Port-level assertions for the reversible byte deque, bound to the top level.
module rbdq_checker #(
  parameter int DEPTH = rbdq_pkg::DEPTH_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [rbdq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                                out_tuser
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A failed operation returns a zero byte.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("failed operation returned a nonzero byte");

  // The reported count never exceeds the depth.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> int'(out_tdata[18:8]) <= DEPTH)
    else $error("count above depth");

  // No new operation is taken while a result waits without being taken.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(in_tvalid && in_tready))
    else $error("operation taken while result slot is busy");

  // The first cycle after a reset cycle shows no result.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

endmodule

bind reversible_byte_deque_unit rbdq_checker #(
  .DEPTH (DEPTH)
) u_rbdq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> tb/rbdq_checker.sv
// Predicts every deque result from the accepted operations and compares it with the block's output.
`timescale 1ns / 100ps

module rbdq_scoreboard #(
  parameter int DEPTH = rbdq_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [rbdq_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [rbdq_pkg::MODE_W-1:0]      in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [rbdq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             out_tuser,
  output int unsigned                      fail_count,
  output int unsigned                      pending
);

  // One result transfer, split into its fields.
  typedef struct packed {
    logic [rbdq_pkg::DATA_W-1:0]  data;
    logic                         ok;
    logic [rbdq_pkg::COUNT_W-1:0] count;
    logic                         rev;
  } deque_out_t;

  // Ring-buffer model of the deque's store and its pointers.
  logic [rbdq_pkg::VALUE_W-1:0] ring [DEPTH];
  int unsigned                  ring_head;
  int unsigned                  ring_fill;
  logic                         ring_flipped;

  deque_out_t  results_due [$];
  int unsigned result_num;

  // Applies one operation to the shadow deque and returns the result it must give.
  function automatic deque_out_t apply_op(rbdq_pkg::mode_t op,
                                          logic [rbdq_pkg::VALUE_W-1:0] value,
                                          logic [rbdq_pkg::INDEX_W-1:0] idx);
    deque_out_t  r;
    logic        at_phys_front;
    int unsigned pos;
    r = '0;
    case (op)
      rbdq_pkg::MODE_PUSH_FRONT, rbdq_pkg::MODE_PUSH_BACK: begin
        if (ring_fill < DEPTH) begin
          at_phys_front = (op == rbdq_pkg::MODE_PUSH_FRONT) != ring_flipped;
          if (at_phys_front) begin
            ring_head = (ring_head + DEPTH - 1) % DEPTH;
            ring[ring_head] = value;
          end else begin
            ring[(ring_head + ring_fill) % DEPTH] = value;
          end
          ring_fill++;
          r.ok = 1'b1;
        end
      end
      rbdq_pkg::MODE_REVERSE: begin
        ring_flipped = !ring_flipped;
        r.ok = 1'b1;
      end
      rbdq_pkg::MODE_POP_FRONT, rbdq_pkg::MODE_POP_BACK: begin
        if (ring_fill > 0) begin
          at_phys_front = (op == rbdq_pkg::MODE_POP_FRONT) != ring_flipped;
          if (at_phys_front) begin
            r.data = ring[ring_head];
            ring_head = (ring_head + 1) % DEPTH;
          end else begin
            r.data = ring[(ring_head + ring_fill - 1) % DEPTH];
          end
          ring_fill--;
          r.ok = 1'b1;
        end
      end
      rbdq_pkg::MODE_READ: begin
        if (idx < ring_fill) begin
          // While flipped, logical index zero is the physical back.
          if (ring_flipped) pos = (ring_head + ring_fill - 1 - idx) % DEPTH;
          else pos = (ring_head + idx) % DEPTH;
          r.data = ring[pos];
          r.ok = 1'b1;
        end
      end
      rbdq_pkg::MODE_CLEAR: begin
        ring_head = 0;
        ring_fill = 0;
        ring_flipped = 1'b0;
        r.ok = 1'b1;
      end
      default: ;
    endcase
    r.count = rbdq_pkg::COUNT_W'(ring_fill);
    r.rev = ring_flipped;
    return r;
  endfunction

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", result_num, msg);
    fail_count++;
  endtask

  // Compare each result transfer first, then predict the operation taken at the same edge.
  always @(posedge clk) begin
    deque_out_t got;
    deque_out_t want;
    if (!rst_n) begin
      ring_head = 0;
      ring_fill = 0;
      ring_flipped = 1'b0;
      results_due.delete();
      result_num = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.data  = out_tdata[rbdq_pkg::DATA_W-1:0];
        got.count = out_tdata[rbdq_pkg::DATA_W+rbdq_pkg::COUNT_W-1:rbdq_pkg::DATA_W];
        got.rev   = out_tdata[rbdq_pkg::DATA_W+rbdq_pkg::COUNT_W];
        got.ok    = out_tuser;
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result 0x%0h with nothing expected", out_tdata));
        end else begin
          want = results_due.pop_front();
          if (got.data !== want.data)
            report_mismatch($sformatf("data 0x%0h, expected 0x%0h", got.data, want.data));
          if (got.ok !== want.ok)
            report_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
          if (got.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d", got.count, want.count));
          if (got.rev !== want.rev)
            report_mismatch($sformatf("reversed %0b, expected %0b", got.rev, want.rev));
        end
        result_num++;
      end
      if (in_tvalid && in_tready)
        results_due = {results_due,
                       apply_op(rbdq_pkg::mode_t'(in_tuser),
                                in_tdata[rbdq_pkg::VALUE_W-1:0],
                                in_tdata[rbdq_pkg::VALUE_W+rbdq_pkg::INDEX_W-1:
                                         rbdq_pkg::VALUE_W])};
    end
    pending <= unsigned'(results_due.size());
  end

endmodule

>>> tb/testbench.sv
// Top of the deque testbench: clock, reset, operation stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH = rbdq_pkg::DEPTH_DEF;
  // Slowest operation is a fetch from the far end plus a few receiver stalls.
  localparam int STALL_LIMIT = 8 * (DEPTH + 2) + 200;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [rbdq_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [rbdq_pkg::MODE_W-1:0]      in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [rbdq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned fill_seen = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;

  always #1 clk = ~clk;

  reversible_byte_deque_unit #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  rbdq_scoreboard #(.DEPTH(DEPTH)) u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // The result side stalls about a quarter of the time, except in steady stretches.
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 24);
  end

  // Ends the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Random byte for the value field.
  function automatic logic [rbdq_pkg::VALUE_W-1:0] rnd_byte();
    return rbdq_pkg::VALUE_W'($urandom_range(0, 255));
  endfunction

  // Random index from zero up to the given bound.
  function automatic logic [rbdq_pkg::INDEX_W-1:0] rnd_idx(int unsigned hi);
    return rbdq_pkg::INDEX_W'($urandom_range(0, hi));
  endfunction

  // Presents one operation from a falling edge and returns at the falling edge after its transfer.
  task automatic send_op(rbdq_pkg::mode_t op, logic [rbdq_pkg::VALUE_W-1:0] value,
                         logic [rbdq_pkg::INDEX_W-1:0] idx);
    while (!steady && $urandom_range(0, 99) < 24) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(rbdq_pkg::IN_TDATA_W - rbdq_pkg::VALUE_W - rbdq_pkg::INDEX_W){1'b0}},
                  idx, value};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    // Rough fill level, used only to steer the random mix.
    case (op)
      rbdq_pkg::MODE_PUSH_FRONT, rbdq_pkg::MODE_PUSH_BACK: if (fill_seen < DEPTH) fill_seen++;
      rbdq_pkg::MODE_POP_FRONT, rbdq_pkg::MODE_POP_BACK:   if (fill_seen > 0) fill_seen--;
      rbdq_pkg::MODE_CLEAR:                                fill_seen = 0;
      default: ;
    endcase
  endtask

  // Random operations that keep the deque around a small fill level.
  task automatic run_mixed_ops(int n, int unsigned cap);
    int unsigned                  sel;
    int unsigned                  push_w;
    rbdq_pkg::mode_t              op;
    logic [rbdq_pkg::INDEX_W-1:0] idx;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      push_w = (fill_seen < cap) ? 45 : 12;
      if (sel < push_w)
        op = $urandom_range(0, 1) ? rbdq_pkg::MODE_PUSH_BACK : rbdq_pkg::MODE_PUSH_FRONT;
      else if (sel < push_w + 8) op = rbdq_pkg::MODE_REVERSE;
      else if (sel < push_w + 10) op = rbdq_pkg::MODE_CLEAR;
      else if (sel < push_w + 40)
        op = $urandom_range(0, 1) ? rbdq_pkg::MODE_POP_BACK : rbdq_pkg::MODE_POP_FRONT;
      else op = rbdq_pkg::MODE_READ;
      // Mostly indexes from zero up to the fill level, sometimes anywhere.
      if ($urandom_range(0, 4) == 0) idx = rnd_idx(1023);
      else idx = rnd_idx(fill_seen);
      send_op(op, rnd_byte(), idx);
    end
  endtask

  // Pushes until the deque is full, with a few reads, pops and reversals on the way.
  task automatic run_fill_to_full();
    int unsigned sel;
    while (fill_seen < DEPTH) begin
      sel = $urandom_range(0, 99);
      if (sel < 95)
        send_op($urandom_range(0, 1) ? rbdq_pkg::MODE_PUSH_BACK : rbdq_pkg::MODE_PUSH_FRONT,
                rnd_byte(), rnd_idx(1023));
      else if (sel < 97)
        send_op(rbdq_pkg::MODE_REVERSE, rnd_byte(), rnd_idx(1023));
      else if (sel < 99)
        send_op(rbdq_pkg::MODE_READ, rnd_byte(), rnd_idx(1023));
      else
        send_op($urandom_range(0, 1) ? rbdq_pkg::MODE_POP_BACK : rbdq_pkg::MODE_POP_FRONT,
                rnd_byte(), rnd_idx(1023));
    end
    // Full deque: pushes fail, both ends read, then two slots freed and refilled.
    send_op(rbdq_pkg::MODE_PUSH_FRONT, 8'h11, 10'd0);
    send_op(rbdq_pkg::MODE_PUSH_BACK, 8'h22, 10'd0);
    send_op(rbdq_pkg::MODE_READ, 8'h00, 10'd1023);
    send_op(rbdq_pkg::MODE_READ, 8'h00, 10'd0);
    send_op(rbdq_pkg::MODE_REVERSE, 8'h00, 10'd0);
    send_op(rbdq_pkg::MODE_READ, 8'h00, 10'd1023);
    send_op(rbdq_pkg::MODE_READ, 8'h00, 10'd0);
    send_op(rbdq_pkg::MODE_POP_BACK, 8'h00, 10'd0);
    send_op(rbdq_pkg::MODE_POP_FRONT, 8'h00, 10'd0);
    send_op(rbdq_pkg::MODE_PUSH_FRONT, 8'hC3, 10'd0);
    send_op(rbdq_pkg::MODE_PUSH_BACK, 8'h3C, 10'd0);
    send_op(rbdq_pkg::MODE_PUSH_BACK, 8'h99, 10'd0);
    send_op(rbdq_pkg::MODE_REVERSE, 8'h00, 10'd0);
    send_op(rbdq_pkg::MODE_CLEAR, 8'h00, 10'd0);
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-deque failures, both push ends, reads in and past range,
    // reversal on empty and loaded deques, and clear while reversed.
    send_op(rbdq_pkg::MODE_POP_FRONT, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_POP_BACK, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd0);
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd1023);
    send_op(rbdq_pkg::MODE_REVERSE, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_REVERSE, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_PUSH_FRONT, 8'h00, rnd_idx(1023));
    send_op(rbdq_pkg::MODE_PUSH_BACK, 8'hFF, rnd_idx(1023));
    send_op(rbdq_pkg::MODE_PUSH_FRONT, 8'hA5, rnd_idx(1023));
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd0);
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd2);
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd3);
    send_op(rbdq_pkg::MODE_REVERSE, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd0);
    send_op(rbdq_pkg::MODE_PUSH_FRONT, 8'h5A, rnd_idx(1023));
    send_op(rbdq_pkg::MODE_PUSH_BACK, 8'h3C, rnd_idx(1023));
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd4);
    send_op(rbdq_pkg::MODE_POP_FRONT, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_POP_BACK, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_CLEAR, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_READ, rnd_byte(), 10'd0);
    send_op(rbdq_pkg::MODE_PUSH_BACK, 8'h81, rnd_idx(1023));
    send_op(rbdq_pkg::MODE_POP_FRONT, rnd_byte(), rnd_idx(1023));
    send_op(rbdq_pkg::MODE_POP_BACK, rnd_byte(), rnd_idx(1023));

    run_mixed_ops(250, 24);

    // Hold off until every outstanding result has drained.
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);

    // The fill to full runs without idling on either side.
    steady = 1'b1;
    run_fill_to_full();
    steady = 1'b0;

    run_mixed_ops(200, 48);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DEPTH + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> reversible_byte_deque_unit.f
hdl/rbdq_pkg.sv
hdl/rbdq_cell.sv
hdl/rbdq_ctrl.sv
hdl/reversible_byte_deque_unit.sv
hdl/rbdq_checker.sv
tb/rbdq_checker.sv
tb/testbench.sv
